// ----- design/assert_macros.svh -----
// Assertion macros shared by the particle stepper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LPES_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpes check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LPES_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpes check failed");

`endif

// ----- design/lpes_pkg.sv -----
// Types and constants for the Lorenz particle Euler step unit.
package lpes_pkg;

    localparam int PARTICLE_COUNT_DEF = 2048;

    localparam int IDX_W   = 11;
    localparam int STEP_W  = 24;
    localparam int COEF_W  = 24;
    localparam int SCALE_W = 16;
    localparam int POS_W   = 32;
    localparam int H_W     = 32;
    // signed width of every derivative handed to the Euler add unit
    localparam int DERIV_W = 50;

    localparam logic [COEF_W-1:0]  SIGMA_RESET = 24'd655360;
    localparam logic [COEF_W-1:0]  RHO_RESET   = 24'd1835008;
    localparam logic [COEF_W-1:0]  BETA_RESET  = 24'd174763;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd6554;

    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        REG_SIGMA = 2'd0,
        REG_RHO   = 2'd1,
        REG_BETA  = 2'd2,
        REG_SCALE = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [IDX_W-1:0]  particle_index;
        logic [STEP_W-1:0] step_time;
    } step_req_t;

    typedef struct packed {
        logic [IDX_W-1:0]        particle_out;
        logic signed [POS_W-1:0] new_x;
        logic signed [POS_W-1:0] new_y;
        logic signed [POS_W-1:0] new_z;
        logic                    clipped;
    } step_rsp_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } pos_t;

    typedef struct packed {
        logic             valid;
        logic             in_range;
        logic [IDX_W-1:0] idx;
    } ctl_t;

    // values riding alongside the x update
    typedef struct packed {
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [H_W-1:0]          h;
        logic signed [33:0]      rmz;
        logic signed [40:0]      bz;
    } carry_a_t;

    // values riding alongside the y update
    typedef struct packed {
        logic signed [POS_W-1:0] nx;
        logic                    clip;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [H_W-1:0]          h;
        logic signed [40:0]      bz;
    } carry_b_t;

    // values riding into the z update
    typedef struct packed {
        logic signed [POS_W-1:0] nx;
        logic signed [POS_W-1:0] ny;
        logic                    clip;
        logic signed [POS_W-1:0] z;
        logic [H_W-1:0]          h;
        logic signed [40:0]      bz;
    } carry_c_t;

    // values riding alongside the z update
    typedef struct packed {
        logic signed [POS_W-1:0] nx;
        logic signed [POS_W-1:0] ny;
        logic                    clip;
    } carry_d_t;

endpackage

// ----- design/lorenz_particle_euler_step_unit.sv -----
// Top level of the Lorenz particle Euler step unit.
// Each step transaction advances one stored particle by one forward Euler step and returns
// its new position from the result register; distinct particles are accepted one per cycle
// while no result is held. The positions live in one memory with a registered read at
// acceptance and a write-back from stage 22, so a transaction naming a particle still in
// flight waits until that particle has been written back. After reset the memory is swept
// to its initial values, during which step_ready stays low;
// configuration writes are taken at any time. A held result stalls the whole pipeline.
`include "assert_macros.svh"

module lorenz_particle_euler_step_unit #(
    parameter int PARTICLE_COUNT = lpes_pkg::PARTICLE_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step_valid,
    output logic                          step_ready,
    input  lpes_pkg::step_req_t           step_req,
    output logic                          result_valid,
    input  logic                          result_ready,
    output lpes_pkg::step_rsp_t           result,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [lpes_pkg::COEF_W-1:0]   cfg_data
);

    localparam int ADDR_W     = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;
    localparam int LAST_STAGE = 22;

    // configuration
    logic [lpes_pkg::COEF_W-1:0]  sigma_reg;
    logic [lpes_pkg::COEF_W-1:0]  rho_reg;
    logic [lpes_pkg::COEF_W-1:0]  beta_reg;
    logic [lpes_pkg::SCALE_W-1:0] scale_reg;

    // control
    lpes_pkg::ctl_t      ctl_reg [1:LAST_STAGE];
    lpes_pkg::step_rsp_t result_reg;
    logic                result_valid_reg;
    logic                adv;
    logic                hazard;
    logic                busy;
    logic                accept;
    logic                in_range;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    lpes_pkg::pos_t      wr_data;
    lpes_pkg::pos_t      pos1;
    logic [39:0]         hprod;

    // datapath registers, numbered by stage
    logic [lpes_pkg::H_W-1:0] h1_reg;
    lpes_pkg::pos_t           pos2_reg;
    logic [lpes_pkg::H_W-1:0] h2_reg;
    logic signed [32:0]       ydx2_reg;
    logic signed [33:0]       rmz2_reg;
    logic signed [57:0]       p1_3_reg;
    logic signed [56:0]       pbz3_reg;
    lpes_pkg::pos_t           pos3_reg;
    logic [lpes_pkg::H_W-1:0] h3_reg;
    logic signed [33:0]       rmz3_reg;
    logic signed [41:0]       dx4_reg;
    logic signed [40:0]       bz4_reg;
    lpes_pkg::pos_t           pos4_reg;
    logic [lpes_pkg::H_W-1:0] h4_reg;
    logic signed [33:0]       rmz4_reg;
    lpes_pkg::carry_a_t       carry_a_reg [5:8];
    logic signed [65:0]       p2_9_reg;
    lpes_pkg::carry_b_t       carry_b_reg [9:15];
    logic signed [49:0]       dyq10_reg;
    logic signed [49:0]       dy11_reg;
    logic signed [63:0]       p4_16_reg;
    lpes_pkg::carry_c_t       carry_c_reg [16:18];
    logic signed [47:0]       nxy17_reg;
    logic signed [49:0]       dz18_reg;
    lpes_pkg::carry_d_t       carry_d_reg [19:22];

    logic [57:0] p1_bias;
    logic [56:0] pbz_bias;
    logic [65:0] p2_bias;
    logic [63:0] p4_bias;

    logic signed [lpes_pkg::DERIV_W-1:0] dx_ext;
    logic signed [lpes_pkg::POS_W-1:0]   nx8;
    logic                                clipx8;
    logic signed [lpes_pkg::POS_W-1:0]   ny15;
    logic                                clipy15;
    logic signed [lpes_pkg::POS_W-1:0]   nz22;
    logic                                clipz22;

    // ---------------------------------------------------------------- handshake
    assign adv        = !result_valid_reg || result_ready;
    assign in_range   = 32'(step_req.particle_index) < 32'(PARTICLE_COUNT);
    assign step_ready = adv && !busy && !hazard;
    assign accept     = step_valid && step_ready;
    assign rd_addr    = ADDR_W'(step_req.particle_index);

    // a particle may only be in flight once: read-modify-write interlock
    always_comb
    begin
        hazard = 1'b0;
        for (int k = 1; k <= LAST_STAGE; k++)
        begin
            if (ctl_reg[k].valid && ctl_reg[k].in_range &&
                ctl_reg[k].idx == step_req.particle_index)
            begin
                hazard = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_reg <= lpes_pkg::SIGMA_RESET;
            rho_reg   <= lpes_pkg::RHO_RESET;
            beta_reg  <= lpes_pkg::BETA_RESET;
            scale_reg <= lpes_pkg::SCALE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (lpes_pkg::cfg_reg_t'(cfg_index))
                lpes_pkg::REG_SIGMA: sigma_reg <= cfg_data;
                lpes_pkg::REG_RHO:   rho_reg   <= cfg_data;
                lpes_pkg::REG_BETA:  beta_reg  <= cfg_data;
                lpes_pkg::REG_SCALE: scale_reg <= cfg_data[lpes_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= LAST_STAGE; k++)
            begin
                ctl_reg[k] <= '0;
            end
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            ctl_reg[1].valid    <= accept;
            ctl_reg[1].in_range <= in_range;
            ctl_reg[1].idx      <= step_req.particle_index;
            for (int k = 2; k <= LAST_STAGE; k++)
            begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
            result_valid_reg <= ctl_reg[LAST_STAGE].valid;
        end
    end

    // ---------------------------------------------------------------- store
    lpes_store #(
        .PARTICLE_COUNT (PARTICLE_COUNT),
        .ADDR_W         (ADDR_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (adv),
        .rd_addr (rd_addr),
        .rd_data (pos1),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .busy    (busy)
    );

    assign wr_en   = adv && ctl_reg[LAST_STAGE].valid && ctl_reg[LAST_STAGE].in_range;
    assign wr_addr = ADDR_W'(ctl_reg[LAST_STAGE].idx);
    assign wr_data = '{x: carry_d_reg[22].nx, y: carry_d_reg[22].ny, z: nz22};

    // ---------------------------------------------------------------- datapath
    // products of Q values drop 16 bits toward zero: bias negatives before the shift
    always_comb
    begin
        hprod    = scale_reg * step_req.step_time;
        p1_bias  = p1_3_reg + {42'd0, {16{p1_3_reg[57]}}};
        pbz_bias = pbz3_reg + {41'd0, {16{pbz3_reg[56]}}};
        p2_bias  = p2_9_reg + {50'd0, {16{p2_9_reg[65]}}};
        p4_bias  = p4_16_reg + {48'd0, {16{p4_16_reg[63]}}};
        dx_ext   = {{8{dx4_reg[41]}}, dx4_reg};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 1
            h1_reg   <= hprod[39:8];
            // stage 2
            pos2_reg <= pos1;
            h2_reg   <= h1_reg;
            ydx2_reg <= {pos1.y[31], pos1.y} - {pos1.x[31], pos1.x};
            rmz2_reg <= {10'd0, rho_reg} - {{2{pos1.z[31]}}, pos1.z};
            // stage 3
            p1_3_reg <= $signed({1'b0, sigma_reg}) * ydx2_reg;
            pbz3_reg <= $signed({1'b0, beta_reg}) * pos2_reg.z;
            pos3_reg <= pos2_reg;
            h3_reg   <= h2_reg;
            rmz3_reg <= rmz2_reg;
            // stage 4
            dx4_reg  <= p1_bias[57:16];
            bz4_reg  <= pbz_bias[56:16];
            pos4_reg <= pos3_reg;
            h4_reg   <= h3_reg;
            rmz4_reg <= rmz3_reg;
            // stages 5..8, beside the x update
            carry_a_reg[5] <= '{y: pos4_reg.y, z: pos4_reg.z, h: h4_reg,
                                rmz: rmz4_reg, bz: bz4_reg};
            for (int k = 6; k <= 8; k++)
            begin
                carry_a_reg[k] <= carry_a_reg[k-1];
            end
            // stage 9
            p2_9_reg       <= nx8 * carry_a_reg[8].rmz;
            carry_b_reg[9] <= '{nx: nx8, clip: clipx8, y: carry_a_reg[8].y,
                                z: carry_a_reg[8].z, h: carry_a_reg[8].h,
                                bz: carry_a_reg[8].bz};
            for (int k = 10; k <= 15; k++)
            begin
                carry_b_reg[k] <= carry_b_reg[k-1];
            end
            // stage 10, 11
            dyq10_reg <= p2_bias[65:16];
            dy11_reg  <= dyq10_reg - {{18{carry_b_reg[10].y[31]}}, carry_b_reg[10].y};
            // stage 16
            p4_16_reg       <= carry_b_reg[15].nx * ny15;
            carry_c_reg[16] <= '{nx: carry_b_reg[15].nx, ny: ny15,
                                 clip: carry_b_reg[15].clip | clipy15,
                                 z: carry_b_reg[15].z, h: carry_b_reg[15].h,
                                 bz: carry_b_reg[15].bz};
            carry_c_reg[17] <= carry_c_reg[16];
            carry_c_reg[18] <= carry_c_reg[17];
            // stage 17, 18
            nxy17_reg <= p4_bias[63:16];
            dz18_reg  <= {{2{nxy17_reg[47]}}, nxy17_reg}
                       - {{9{carry_c_reg[17].bz[40]}}, carry_c_reg[17].bz};
            // stages 19..22, beside the z update
            carry_d_reg[19] <= '{nx: carry_c_reg[18].nx, ny: carry_c_reg[18].ny,
                                 clip: carry_c_reg[18].clip};
            for (int k = 20; k <= 22; k++)
            begin
                carry_d_reg[k] <= carry_d_reg[k-1];
            end
            // result register
            if (ctl_reg[LAST_STAGE].valid)
            begin
                result_reg.particle_out <= ctl_reg[LAST_STAGE].idx;
                if (ctl_reg[LAST_STAGE].in_range)
                begin
                    result_reg.new_x   <= carry_d_reg[22].nx;
                    result_reg.new_y   <= carry_d_reg[22].ny;
                    result_reg.new_z   <= nz22;
                    result_reg.clipped <= carry_d_reg[22].clip | clipz22;
                end
                else
                begin
                    result_reg.new_x   <= '0;
                    result_reg.new_y   <= '0;
                    result_reg.new_z   <= '0;
                    result_reg.clipped <= 1'b0;
                end
            end
        end
    end

    lpes_euler_add #(
        .D_W (lpes_pkg::DERIV_W)
    ) u_step_x (
        .clk  (clk),
        .en   (adv),
        .d    (dx_ext),
        .base (pos4_reg.x),
        .h    (h4_reg),
        .sum  (nx8),
        .clip (clipx8)
    );

    lpes_euler_add #(
        .D_W (lpes_pkg::DERIV_W)
    ) u_step_y (
        .clk  (clk),
        .en   (adv),
        .d    (dy11_reg),
        .base (carry_b_reg[11].y),
        .h    (carry_b_reg[11].h),
        .sum  (ny15),
        .clip (clipy15)
    );

    lpes_euler_add #(
        .D_W (lpes_pkg::DERIV_W)
    ) u_step_z (
        .clk  (clk),
        .en   (adv),
        .d    (dz18_reg),
        .base (carry_c_reg[18].z),
        .h    (carry_c_reg[18].h),
        .sum  (nz22),
        .clip (clipz22)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ---------------------------------------------------------------- checks
    `LPES_ASSERT_IMP(a_no_accept_while_sweeping, busy, !step_ready)
    `LPES_ASSERT_IMP(a_no_rmw_overlap, accept && in_range && wr_en, wr_addr != rd_addr)
    `LPES_ASSERT_NXT(a_no_result_while_sweeping, busy, !result_valid)
    `LPES_ASSERT_IMP(a_clip_means_saturated, result_valid && result.clipped, (result.new_x == lpes_pkg::POS_MAX) || (result.new_x == lpes_pkg::POS_MIN) || (result.new_y == lpes_pkg::POS_MAX) || (result.new_y == lpes_pkg::POS_MIN) || (result.new_z == lpes_pkg::POS_MAX) || (result.new_z == lpes_pkg::POS_MIN))
    `LPES_ASSERT_IMP(a_out_of_range_zero, result_valid && (32'(result.particle_out) >= 32'(PARTICLE_COUNT)), (result.new_x == 0) && (result.new_y == 0) && (result.new_z == 0) && !result.clipped)

endmodule

// ----- design/lpes_store.sv -----
// Particle position memory with its post-reset initialization sweep.
module lpes_store #(
    parameter int PARTICLE_COUNT = lpes_pkg::PARTICLE_COUNT_DEF,
    parameter int ADDR_W         = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output lpes_pkg::pos_t      rd_data,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  lpes_pkg::pos_t      wr_data,
    output logic                busy
);

    lpes_pkg::pos_t    mem [PARTICLE_COUNT];
    lpes_pkg::pos_t    rd_data_reg;
    lpes_pkg::pos_t    init_pos;
    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_idx_reg;
    logic [16:0]       ip1;

    // x starts at index + 1, clamped once it no longer fits Q16.16
    always_comb
    begin
        ip1        = 17'(clr_idx_reg) + 17'd1;
        init_pos.y = '0;
        init_pos.z = '0;
        if (ip1[16] || ip1[15])
        begin
            init_pos.x = lpes_pkg::POS_MAX;
        end
        else
        begin
            init_pos.x = {ip1[15:0], 16'h0000};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == ADDR_W'(PARTICLE_COUNT - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_idx_reg] <= init_pos;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clearing_reg;

endmodule

// ----- design/lpes_euler_add.sv -----
// Four-stage unit: sat(base + (d * h) >> 32), truncated toward zero.
module lpes_euler_add #(
    parameter int D_W = lpes_pkg::DERIV_W
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [D_W-1:0]              d,
    input  logic signed [lpes_pkg::POS_W-1:0]  base,
    input  logic [lpes_pkg::H_W-1:0]           h,
    output logic signed [lpes_pkg::POS_W-1:0]  sum,
    output logic                               clip
);

    // stage a: magnitude
    logic [D_W-1:0]                     mag_reg;
    logic                               neg_a_reg;
    logic signed [lpes_pkg::POS_W-1:0]  base_a_reg;
    logic [lpes_pkg::H_W-1:0]           h_a_reg;
    // stage b: split partial products
    logic [63:0]                        plo_reg;
    logic [D_W-1:0]                     phi_reg;
    logic                               neg_b_reg;
    logic signed [lpes_pkg::POS_W-1:0]  base_b_reg;
    // stage c: combined magnitude of the step
    logic [D_W-1:0]                     r_reg;
    logic                               neg_c_reg;
    logic signed [lpes_pkg::POS_W-1:0]  base_c_reg;
    // stage d: saturated sum
    logic signed [lpes_pkg::POS_W-1:0]  sum_reg;
    logic                               clip_reg;

    logic signed [D_W+1:0]              base_ext;
    logic signed [D_W+1:0]              r_ext;
    logic signed [D_W+1:0]              sum_w;
    logic signed [lpes_pkg::POS_W-1:0]  sum_next;
    logic                               clip_next;

    always_comb
    begin
        base_ext = {{(D_W-30){base_c_reg[31]}}, base_c_reg};
        r_ext    = {2'b00, r_reg};
        sum_w    = neg_c_reg ? (base_ext - r_ext) : (base_ext + r_ext);
        if ((&sum_w[D_W+1:31]) || !(|sum_w[D_W+1:31]))
        begin
            sum_next  = sum_w[31:0];
            clip_next = 1'b0;
        end
        else
        begin
            sum_next  = sum_w[D_W+1] ? lpes_pkg::POS_MIN : lpes_pkg::POS_MAX;
            clip_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg    <= d[D_W-1] ? (~d + 1'b1) : d;
            neg_a_reg  <= d[D_W-1];
            base_a_reg <= base;
            h_a_reg    <= h;

            plo_reg    <= mag_reg[31:0] * h_a_reg;
            phi_reg    <= mag_reg[D_W-1:32] * h_a_reg;
            neg_b_reg  <= neg_a_reg;
            base_b_reg <= base_a_reg;

            r_reg      <= phi_reg + D_W'(plo_reg[63:32]);
            neg_c_reg  <= neg_b_reg;
            base_c_reg <= base_b_reg;

            sum_reg    <= sum_next;
            clip_reg   <= clip_next;
        end
    end

    assign sum  = sum_reg;
    assign clip = clip_reg;

endmodule

// ----- tb/tb_lorenz_particle_euler_step_unit.sv -----
// Self-checking testbench for the Lorenz particle Euler step unit.
module tb_lorenz_particle_euler_step_unit;
    import lpes_pkg::*;

    localparam int PARTICLE_COUNT = PARTICLE_COUNT_DEF;
    localparam int QUIET_LIMIT    = 20000;
    localparam int DRAIN_CYCLES   = 30;

    // Tracks particle positions and the results still owed by the block.
    class particle_board;
        pos_t              positions [PARTICLE_COUNT];
        logic [COEF_W-1:0] sigma;
        logic [COEF_W-1:0] rho;
        logic [COEF_W-1:0] beta;
        logic [SCALE_W-1:0] scale;
        step_rsp_t         predicted_steps [$];
        int                errors;

        function new();
            for (int i = 0; i < PARTICLE_COUNT; i++)
            begin
                positions[i].x = ((i + 1) << 16 > POS_MAX) ? POS_MAX : (i + 1) << 16;
                positions[i].y = '0;
                positions[i].z = '0;
            end
            sigma  = SIGMA_RESET;
            rho    = RHO_RESET;
            beta   = BETA_RESET;
            scale  = SCALE_RESET;
            errors = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [COEF_W-1:0] val);
            case (idx)
                REG_SIGMA: sigma = val;
                REG_RHO:   rho = val;
                REG_BETA:  beta = val;
                REG_SCALE: scale = val[SCALE_W-1:0];
                default:   ;
            endcase
        endfunction

        // exact product >> 16, truncated on the magnitude
        function longint q16_mul(longint a, longint b);
            logic [63:0]  ma;
            logic [63:0]  mb;
            logic [127:0] p;
            ma = (a < 0) ? -a : a;
            mb = (b < 0) ? -b : b;
            p  = (128'(ma) * 128'(mb)) >> 16;
            return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
        endfunction

        // derivative times step, >> 32, truncated on the magnitude
        function longint dt_scale(longint d, logic [H_W-1:0] h);
            logic [63:0]  m;
            logic [127:0] p;
            m = (d < 0) ? -d : d;
            p = (128'(m) * 128'(h)) >> 32;
            return (d < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
        endfunction

        function logic signed [POS_W-1:0] clamp32(longint v, inout bit clip);
            if (v > longint'(POS_MAX))
            begin
                clip = 1'b1;
                return POS_MAX;
            end
            if (v < longint'(POS_MIN))
            begin
                clip = 1'b1;
                return POS_MIN;
            end
            return v[POS_W-1:0];
        endfunction

        function step_rsp_t euler_advance(step_req_t req);
            step_rsp_t               r;
            logic [39:0]             hp;
            logic [H_W-1:0]          h;
            longint                  x;
            longint                  y;
            longint                  z;
            longint                  d;
            logic signed [POS_W-1:0] nx;
            logic signed [POS_W-1:0] ny;
            logic signed [POS_W-1:0] nz;
            bit                      clip;
            r = '0;
            r.particle_out = req.particle_index;
            if (req.particle_index >= PARTICLE_COUNT)
                return r;
            hp   = scale * req.step_time;
            h    = hp[39:8];
            clip = 1'b0;
            x = positions[req.particle_index].x;
            y = positions[req.particle_index].y;
            z = positions[req.particle_index].z;
            d  = q16_mul(longint'(sigma), y - x);
            nx = clamp32(x + dt_scale(d, h), clip);
            d  = q16_mul(nx, longint'(rho) - z) - y;
            ny = clamp32(y + dt_scale(d, h), clip);
            d  = q16_mul(nx, ny) - q16_mul(longint'(beta), z);
            nz = clamp32(z + dt_scale(d, h), clip);
            positions[req.particle_index] = '{x: nx, y: ny, z: nz};
            r.new_x   = nx;
            r.new_y   = ny;
            r.new_z   = nz;
            r.clipped = clip;
            return r;
        endfunction

        function void note_step(step_req_t req);
            predicted_steps.push_back(euler_advance(req));
        endfunction

        function void report(string what, int particle, logic signed [63:0] want,
                             logic signed [63:0] seen);
            errors++;
            $display("%0t: particle %0d %s expected %0d, got %0d",
                     $time, particle, what, want, seen);
        endfunction

        function void check_result(step_rsp_t got);
            step_rsp_t want;
            if (predicted_steps.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result for particle %0d: %p", $time,
                         got.particle_out, got);
                return;
            end
            want = predicted_steps.pop_front();
            if (got.particle_out !== want.particle_out)
                report("particle_out", want.particle_out, want.particle_out, got.particle_out);
            if (got.new_x !== want.new_x)
                report("new_x", want.particle_out, want.new_x, got.new_x);
            if (got.new_y !== want.new_y)
                report("new_y", want.particle_out, want.new_y, got.new_y);
            if (got.new_z !== want.new_z)
                report("new_z", want.particle_out, want.new_z, got.new_z);
            if (got.clipped !== want.clipped)
                report("clipped", want.particle_out, want.clipped, got.clipped);
        endfunction

        function int pending();
            return predicted_steps.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              step_valid;
    logic              step_ready;
    step_req_t         step_req;
    logic              result_valid;
    logic              result_ready;
    step_rsp_t         result;
    logic              cfg_we;
    cfg_reg_t          cfg_index;
    logic [COEF_W-1:0] cfg_data;

    particle_board board;
    int            send_idle_pct;
    int            stall_pct;
    int            quiet_cycles;
    logic [IDX_W-1:0] pool_base;

    lorenz_particle_euler_step_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_valid   (step_valid),
        .step_ready   (step_ready),
        .step_req     (step_req),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(negedge clk)
        result_ready <= ($urandom_range(99) >= stall_pct);

    // transaction monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
                board.check_result(result);
            if (step_valid && step_ready)
                board.note_step(step_req);
            if ((result_valid && result_ready) || (step_valid && step_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_lorenz_particle_euler_step_unit: done, errors");
                $finish;
            end
        end
    end

    // valid stays up from one transaction to the next unless the sender idles
    task automatic send_step(logic [IDX_W-1:0] idx, logic [STEP_W-1:0] st);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            step_valid <= 1'b0;
            @(negedge clk);
        end
        step_valid <= 1'b1;
        step_req   <= '{particle_index: idx, step_time: st};
        @(posedge clk);
        while (!step_ready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        @(negedge clk);
        step_valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
    endtask

    task automatic apply_config(logic [COEF_W-1:0] s, logic [COEF_W-1:0] r,
                                logic [COEF_W-1:0] b, logic [COEF_W-1:0] t);
        logic [COEF_W-1:0] vals [4];
        vals = '{s, r, b, t};
        for (int i = 0; i < 4; i++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= cfg_reg_t'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            board.write_reg(cfg_reg_t'(i), vals[i]);
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return COEF_W'($urandom_range(24'h3FFFFF));
        endcase
    endfunction

    // the scale value gets random junk in the unused upper bits
    task automatic random_config();
        apply_config(pick_coef(), pick_coef(), pick_coef(),
                     {8'($urandom_range(255)), 16'(pick_coef())});
    endtask

    task automatic random_step();
        logic [IDX_W-1:0]  idx;
        logic [STEP_W-1:0] st;
        // mostly a small pool so particles get stepped many times and collide in flight
        if ($urandom_range(9) < 6)
            idx = pool_base + IDX_W'($urandom_range(7));
        else
            idx = IDX_W'($urandom_range(PARTICLE_COUNT - 1));
        case ($urandom_range(9))
            0, 1, 2, 3: st = STEP_W'($urandom_range(24'hFFFFFF));
            4, 5, 6, 7: st = STEP_W'($urandom_range(24'h00FFFF));
            8:          st = $urandom_range(1) ? '1 : '0;
            default:    st = 24'd1 << $urandom_range(STEP_W - 1);
        endcase
        send_step(idx, st);
    endtask

    task automatic run_phase(int items, int idle, int stall);
        send_idle_pct = idle;
        stall_pct     = stall;
        pool_base     = IDX_W'($urandom_range(PARTICLE_COUNT - 8));
        for (int i = 0; i < items; i++)
            random_step();
        drain_results();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        step_valid    = 1'b0;
        step_req      = '0;
        result_ready  = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_SIGMA;
        cfg_data      = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        quiet_cycles  = 0;
        pool_base     = '0;
        board         = new();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // reset coefficients: zero step, full step, back-to-back on one particle
        send_step(11'd0, 24'd0);
        send_step(11'd0, 24'hFFFFFF);
        send_step(11'd0, 24'hFFFFFF);
        send_step(11'd0, 24'd1);
        send_step(11'd2047, 24'hFFFFFF);
        send_step(11'd2047, 24'h800000);
        send_step(11'd1, 24'h400000);
        send_step(11'd1024, 24'h123456);
        send_step(11'd1023, 24'hFFFFFF);
        drain_results();

        // largest coefficients: positions run into both rails
        apply_config('1, '1, '1, '1);
        send_step(11'd5, 24'hFFFFFF);
        send_step(11'd5, 24'hFFFFFF);
        send_step(11'd5, 24'hFFFFFF);
        send_step(11'd5, 24'hFFFFFF);
        send_step(11'd6, 24'hFFFFFF);
        send_step(11'd6, 24'hFFFFFF);
        send_step(11'd2047, 24'hFFFFFF);
        send_step(11'd2047, 24'hFFFFFF);
        drain_results();

        // zero scale freezes everything
        apply_config('0, '0, '0, '0);
        send_step(11'd5, 24'hFFFFFF);
        send_step(11'd2047, 24'hFFFFFF);
        drain_results();

        apply_config('0, '1, '0, 24'h00FFFF);
        send_step(11'd7, 24'hFFFFFF);
        send_step(11'd7, 24'hFFFFFF);
        send_step(11'd8, 24'h000100);
        drain_results();

        apply_config(SIGMA_RESET, RHO_RESET, BETA_RESET, SCALE_RESET);
        run_phase(400, 0, 0);
        random_config();
        run_phase(300, 88, 0);
        random_config();
        run_phase(300, 0, 88);
        random_config();
        run_phase(200, 23, 23);
        run_phase(200, 23, 23);
        apply_config('1, '0, '1, 24'h00FFFF);
        run_phase(150, 0, 0);

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("tb_lorenz_particle_euler_step_unit: done, clean");
        else
            $display("tb_lorenz_particle_euler_step_unit: done, errors");
        $finish;
    end
endmodule
